[sv/pisc_pkg.sv]
// Shared types, constants and elaboration-time functions for the PID and
// iteration step size controller. No dependencies.
package pisc_pkg;

	localparam int STEP_W     = 40;
	localparam int ITER_W     = 8;
	localparam int ERR_W      = 32;
	localparam int CASE_W     = 2;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 40;
	localparam int DIV_W      = 64;
	localparam int DVS_W      = 32;
	localparam int LOG_W      = 21;
	localparam int ACC_W      = 43;
	localparam int CNT_W      = 6;

	localparam logic [CFG_IDX_W-1:0] CFG_TOLERANCE   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_TARGET_ITER = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_DECAY       = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_GROWTH      = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_MIN_STEP    = 3'd4;

	localparam logic [ERR_W-1:0]  TOL_RESET    = 32'd26843546;
	localparam logic [7:0]        TARGET_RESET = 8'd8;
	localparam logic [15:0]       DAMP_RESET   = 16'd4096;
	localparam logic [STEP_W-1:0] STEP_MAX     = {STEP_W{1'b1}};

	localparam logic [CASE_W-1:0] PC_OVER_TOL  = 2'd0;
	localparam logic [CASE_W-1:0] PC_ZERO_HIST = 2'd1;
	localparam logic [CASE_W-1:0] PC_POWER     = 2'd2;

	// Gains in Q0.20.
	localparam logic [17:0] KP_Q20 = 18'd78643;
	localparam logic [17:0] KI_Q20 = 18'd183501;
	localparam logic [17:0] KD_Q20 = 18'd10486;

	localparam logic [CNT_W-1:0] DIV_LAST  = 6'd63;
	localparam logic [CNT_W-1:0] SQ_LAST   = 6'd15;
	localparam logic [CNT_W-1:0] EXP_LAST  = 6'd15;
	localparam logic [CNT_W-1:0] LSUM_LAST = 6'd2;
	localparam logic [1:0]       LOG_LAST  = 2'd3;

	typedef logic [15:0][31:0] root_tbl_t;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_ITER_MUL,
		ST_ITER_PREP,
		ST_ITER_DIV,
		ST_ITER_FIN,
		ST_PID_DIV_LD,
		ST_PID_DIV,
		ST_MANT,
		ST_LOG_LD,
		ST_LOG_SQ,
		ST_LOG_ST,
		ST_LSUM,
		ST_EXP_LD,
		ST_EXP,
		ST_MUL_LO,
		ST_MUL_HI,
		ST_PID_FIN,
		ST_FINISH
	} pisc_state_t;

	typedef struct packed {
		logic             accept;
		logic             iter_mul;
		logic             iter_prep;
		logic             div_pid;
		logic             div_step;
		logic             iter_fin;
		logic             mant_div;
		logic             log_load;
		logic             log_sq;
		logic             log_store;
		logic             lsum;
		logic             exp_load;
		logic             exp_step;
		logic             fmul_lo;
		logic             fmul_hi;
		logic             pid_fin;
		logic             load_out;
		logic [CNT_W-1:0] cnt;
		logic [1:0]       log_idx;
	} pisc_cmd_t;

	typedef struct packed {
		logic [CASE_W-1:0] pcase;
	} pisc_status_t;

	function automatic longint unsigned isqrt64(longint unsigned v);
		longint unsigned res;
		longint unsigned bv;
		longint unsigned rem;
		res = 0;
		rem = v;
		bv  = 64'h4000_0000_0000_0000;
		while (bv > rem) bv = bv >> 2;
		while (bv != 0) begin
			if (rem >= res + bv) begin
				rem = rem - (res + bv);
				res = (res >> 1) + bv;
			end else begin
				res = res >> 1;
			end
			bv = bv >> 2;
		end
		return res;
	endfunction

	// Entry k holds the Q2.30 factor 2^(2^-(k+1)), built by repeated roots.
	function automatic root_tbl_t root_table();
		root_tbl_t       tbl;
		longint unsigned c;
		c = 64'h8000_0000;
		for (int k = 0; k < 16; k++) begin
			c = isqrt64(c << 30);
			tbl[k] = c[31:0];
		end
		return tbl;
	endfunction

endpackage

[sv/pisc_in_if.sv]
// Input channel of the step controller: one beat per solver step.
// Depends on pisc_pkg.
interface pisc_in_if import pisc_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [STEP_W-1:0] step_size;
	logic [ITER_W-1:0] iteration_count;
	logic [ERR_W-1:0]  rel_change;

	modport source(output valid, step_size, iteration_count, rel_change, input ready);
	modport sink(input valid, step_size, iteration_count, rel_change, output ready);
endinterface

[sv/pisc_out_if.sv]
// Result channel of the step controller: one beat per accepted input.
// Depends on pisc_pkg.
interface pisc_out_if import pisc_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [STEP_W-1:0] new_step;
	logic [CASE_W-1:0] pid_case;

	modport source(output valid, new_step, pid_case, input ready);
	modport sink(input valid, new_step, pid_case, output ready);
endinterface

[sv/pisc_cfg_if.sv]
// Register write channel of the step controller.
// Depends on pisc_pkg.
interface pisc_cfg_if import pisc_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

[sv/pisc_div.sv]
// Restoring divider, one quotient bit per step, 64-bit dividend by 32-bit divisor.
// Depends on pisc_pkg.
module pisc_div import pisc_pkg::*; (
	input  logic             clk,
	input  logic             load,
	input  logic             step,
	input  logic [DIV_W-1:0] dividend,
	input  logic [DVS_W-1:0] divisor,
	output logic [DIV_W-1:0] quotient
);
	logic [DIV_W-1:0] dq_q;
	logic [DVS_W-1:0] rem_q;
	logic [DVS_W-1:0] dvs_q;
	logic [DVS_W:0]   trial;
	logic             fits;

	assign trial = {rem_q, dq_q[DIV_W-1]};
	assign fits  = trial >= {1'b0, dvs_q};

	always_ff @(posedge clk) begin
		if (load) begin
			dq_q  <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (step) begin
			// The remainder stays below the divisor, so it fits in 32 bits.
			rem_q <= fits ? DVS_W'(trial - {1'b0, dvs_q}) : trial[DVS_W-1:0];
			dq_q  <= {dq_q[DIV_W-2:0], fits};
		end
	end

	assign quotient = dq_q;
endmodule

[sv/pisc_ctrl.sv]
// Sequencer of the step controller: walks the datapath through one item.
// Depends on pisc_pkg.
module pisc_ctrl import pisc_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         in_valid,
	output logic         in_ready,
	output logic         out_valid,
	input  logic         out_ready,
	input  pisc_status_t status,
	output pisc_cmd_t    cmd
);
	pisc_state_t      state_q, state_d;
	logic [CNT_W-1:0] cnt_q;
	logic [1:0]       log_idx_q;
	logic             out_valid_q;
	logic             out_free;

	assign out_free = !out_valid_q || out_ready;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:       if (in_valid) state_d = ST_ITER_MUL;
			ST_ITER_MUL:   state_d = ST_ITER_PREP;
			ST_ITER_PREP:  state_d = ST_ITER_DIV;
			ST_ITER_DIV:   if (cnt_q == DIV_LAST) state_d = ST_ITER_FIN;
			ST_ITER_FIN: begin
				unique case (status.pcase)
					PC_OVER_TOL:  state_d = ST_PID_DIV_LD;
					PC_ZERO_HIST: state_d = ST_PID_FIN;
					default:      state_d = ST_LOG_LD;
				endcase
			end
			ST_PID_DIV_LD: state_d = ST_PID_DIV;
			ST_PID_DIV:    if (cnt_q == DIV_LAST) state_d = ST_MANT;
			ST_MANT:       state_d = ST_MUL_LO;
			ST_LOG_LD:     state_d = ST_LOG_SQ;
			ST_LOG_SQ:     if (cnt_q == SQ_LAST) state_d = ST_LOG_ST;
			ST_LOG_ST:     state_d = (log_idx_q == LOG_LAST) ? ST_LSUM : ST_LOG_LD;
			ST_LSUM:       if (cnt_q == LSUM_LAST) state_d = ST_EXP_LD;
			ST_EXP_LD:     state_d = ST_EXP;
			ST_EXP:        if (cnt_q == EXP_LAST) state_d = ST_MUL_LO;
			ST_MUL_LO:     state_d = ST_MUL_HI;
			ST_MUL_HI:     state_d = ST_PID_FIN;
			ST_PID_FIN:    state_d = ST_FINISH;
			ST_FINISH:     if (out_free) state_d = ST_IDLE;
			default:       state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd         = '0;
		cmd.cnt     = cnt_q;
		cmd.log_idx = log_idx_q;
		in_ready    = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready   = 1'b1;
				cmd.accept = in_valid;
			end
			ST_ITER_MUL:   cmd.iter_mul  = 1'b1;
			ST_ITER_PREP:  cmd.iter_prep = 1'b1;
			ST_ITER_DIV:   cmd.div_step  = 1'b1;
			ST_ITER_FIN:   cmd.iter_fin  = 1'b1;
			ST_PID_DIV_LD: cmd.div_pid   = 1'b1;
			ST_PID_DIV:    cmd.div_step  = 1'b1;
			ST_MANT:       cmd.mant_div  = 1'b1;
			ST_LOG_LD:     cmd.log_load  = 1'b1;
			ST_LOG_SQ:     cmd.log_sq    = 1'b1;
			ST_LOG_ST:     cmd.log_store = 1'b1;
			ST_LSUM:       cmd.lsum      = 1'b1;
			ST_EXP_LD:     cmd.exp_load  = 1'b1;
			ST_EXP:        cmd.exp_step  = 1'b1;
			ST_MUL_LO:     cmd.fmul_lo   = 1'b1;
			ST_MUL_HI:     cmd.fmul_hi   = 1'b1;
			ST_PID_FIN:    cmd.pid_fin   = 1'b1;
			ST_FINISH:     cmd.load_out  = out_free;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			log_idx_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			// Each loop state counts its own iterations from zero.
			cnt_q   <= (state_d == state_q) ? cnt_q + 1'b1 : '0;
			if (cmd.accept) begin
				log_idx_q <= '0;
			end else if (cmd.log_store) begin
				log_idx_q <= log_idx_q + 1'b1;
			end
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;
endmodule

[sv/pisc_dp.sv]
// Datapath of the step controller: registers, error history, log/exp units,
// shared divider and the output register. Depends on pisc_pkg and pisc_div.
module pisc_dp import pisc_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  pisc_cmd_t             cmd,
	input  logic [STEP_W-1:0]     step_size,
	input  logic [ITER_W-1:0]     iteration_count,
	input  logic [ERR_W-1:0]      rel_change,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output pisc_status_t          status,
	output logic [STEP_W-1:0]     new_step,
	output logic [CASE_W-1:0]     pid_case
);
	localparam root_tbl_t ROOT_TBL = root_table();
	localparam logic signed [ACC_W-1:0] LOG_BIAS = 43'sd1 <<< 41;

	logic [ERR_W-1:0]  tol_q;
	logic [7:0]        tgt_q;
	logic [15:0]       decay_q;
	logic [15:0]       growth_q;
	logic [STEP_W-1:0] min_q;
	logic [ERR_W-1:0]  hist_q [3];

	logic [STEP_W-1:0] dt_q;
	logic [ITER_W-1:0] n_q;
	logic [47:0]       prod_q;
	logic [23:0]       dterm_q;
	logic              grow_q;
	logic [CASE_W-1:0] pcase_q;
	logic [STEP_W-1:0] iter_q;
	logic [STEP_W-1:0] pid_q;

	logic [31:0]       y_q;
	logic [4:0]        ipart_q;
	logic [15:0]       lfrac_q;
	logic [LOG_W-1:0]  lval_q [4];
	logic signed [ACC_W-1:0] acc_q;
	logic [15:0]       efrac_q;
	logic [31:0]       mant_q;
	logic [5:0]        shamt_q;
	logic              sat_q;
	logic [63:0]       plo_q;
	logic [71:0]       prod72_q;

	// Iteration estimate operands.
	logic [7:0]  teff;
	logic        grow;
	logic [7:0]  tsel;
	logic [7:0]  ndiff;
	logic [63:0] gprod;
	logic [24:0] dec_den;
	logic [DIV_W-1:0] div_dividend;
	logic [DVS_W-1:0] div_divisor;
	logic [DIV_W-1:0] quo;
	logic [64:0] gsum;
	logic [STEP_W-1:0] iter_d;
	logic [CASE_W-1:0] pcase_d;

	// Log unit.
	logic [31:0] lx;
	logic [4:0]  top;
	logic [31:0] norm;
	logic [63:0] sq;
	logic [32:0] sqt;

	// Log combination.
	logic signed [23:0] e0, e1, e2, et;
	logic signed [23:0] dsel;
	logic signed [18:0] ksel;
	logic signed [ACC_W-1:0] term;

	// Exp and final product.
	logic [5:0]  ip;
	logic [63:0] mprod;
	logic        ebit;
	logic [39:0] phi;
	logic [71:0] shifted;
	logic [STEP_W-1:0] pid_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tol_q     <= TOL_RESET;
			tgt_q     <= TARGET_RESET;
			decay_q   <= DAMP_RESET;
			growth_q  <= DAMP_RESET;
			min_q     <= '0;
			hist_q[0] <= TOL_RESET;
			hist_q[1] <= TOL_RESET;
			hist_q[2] <= TOL_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_TOLERANCE: begin
					tol_q     <= cfg_data[ERR_W-1:0];
					hist_q[0] <= cfg_data[ERR_W-1:0];
					hist_q[1] <= cfg_data[ERR_W-1:0];
					hist_q[2] <= cfg_data[ERR_W-1:0];
				end
				CFG_TARGET_ITER: tgt_q    <= cfg_data[7:0];
				CFG_DECAY:       decay_q  <= cfg_data[15:0];
				CFG_GROWTH:      growth_q <= cfg_data[15:0];
				CFG_MIN_STEP:    min_q    <= cfg_data[STEP_W-1:0];
				default: ;
			endcase
		end else if (cmd.accept) begin
			hist_q[0] <= hist_q[1];
			hist_q[1] <= hist_q[2];
			hist_q[2] <= rel_change;
		end
	end

	assign teff  = (tgt_q == 8'd0) ? 8'd1 : tgt_q;
	assign grow  = n_q <= teff;
	assign tsel  = grow ? 8'(teff - n_q) : teff;
	assign ndiff = 8'(n_q - teff);

	always_comb begin
		priority if (hist_q[2] > tol_q) begin
			pcase_d = PC_OVER_TOL;
		end else if (hist_q[0] == '0 || hist_q[1] == '0 || hist_q[2] == '0) begin
			pcase_d = PC_ZERO_HIST;
		end else begin
			pcase_d = PC_POWER;
		end
	end

	// Growth divides by T*4096: drop the 4096 first, then divide by T.
	assign gprod   = prod_q * growth_q;
	assign dec_den = {5'b0, teff, 12'b0} + {1'b0, dterm_q};

	always_comb begin
		if (cmd.div_pid) begin
			div_dividend = {tol_q, 32'b0};
			div_divisor  = hist_q[2];
		end else if (grow_q) begin
			div_dividend = {12'b0, gprod[63:12]};
			div_divisor  = {24'b0, teff};
		end else begin
			div_dividend = {4'b0, prod_q, 12'b0};
			div_divisor  = {7'b0, dec_den};
		end
	end

	pisc_div u_div (
		.clk      (clk),
		.load     (cmd.iter_prep | cmd.div_pid),
		.step     (cmd.div_step),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.quotient (quo)
	);

	assign gsum = {25'b0, dt_q} + {1'b0, quo};

	always_comb begin
		if (grow_q) begin
			iter_d = (gsum[64:40] != '0) ? STEP_MAX : gsum[39:0];
		end else begin
			iter_d = (quo[39:0] < min_q) ? min_q : quo[39:0];
		end
	end

	// Log unit: integer part from the top set bit, fraction by squaring.
	always_comb begin
		unique case (cmd.log_idx)
			2'd0: lx = hist_q[0];
			2'd1: lx = hist_q[1];
			2'd2: lx = hist_q[2];
			default: lx = tol_q;
		endcase
	end

	always_comb begin
		top = '0;
		for (int i = 0; i < 32; i++) begin
			if (lx[i]) top = 5'(i);
		end
	end

	assign norm = lx << (5'd31 - top);
	assign sq   = y_q * y_q;
	assign sqt  = sq[63:31];

	assign e0 = $signed({3'b0, lval_q[0]});
	assign e1 = $signed({3'b0, lval_q[1]});
	assign e2 = $signed({3'b0, lval_q[2]});
	assign et = $signed({3'b0, lval_q[3]});

	always_comb begin
		unique case (cmd.cnt[1:0])
			2'd0: begin
				ksel = $signed({1'b0, KP_Q20});
				dsel = e1 - e2;
			end
			2'd1: begin
				ksel = $signed({1'b0, KI_Q20});
				dsel = et - e2;
			end
			default: begin
				ksel = $signed({1'b0, KD_Q20});
				dsel = (e1 <<< 1) - e0 - e2;
			end
		endcase
	end

	assign term = ksel * dsel;

	// After biasing by 32 in Q36 the sum is positive; bits 41:36 are the
	// biased integer part and bits 35:20 the Q16 fraction.
	assign ip    = acc_q[41:36];
	assign ebit  = efrac_q[4'd15 - cmd.cnt[3:0]];
	assign mprod = mant_q * ROOT_TBL[cmd.cnt[3:0]];
	assign phi   = dt_q[39:32] * mant_q;

	assign shifted = prod72_q >> shamt_q;
	assign pid_d   = (pcase_q == PC_ZERO_HIST || sat_q || shifted[71:40] != '0)
		? STEP_MAX : shifted[39:0];

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			dt_q <= step_size;
			n_q  <= iteration_count;
		end
		if (cmd.iter_mul) begin
			prod_q  <= dt_q * tsel;
			dterm_q <= ndiff * decay_q;
			grow_q  <= grow;
			pcase_q <= pcase_d;
		end
		if (cmd.iter_fin) begin
			iter_q <= iter_d;
		end
		if (cmd.log_load) begin
			y_q     <= norm;
			ipart_q <= top;
			lfrac_q <= '0;
		end
		if (cmd.log_sq) begin
			y_q     <= sqt[32] ? sqt[32:1] : sqt[31:0];
			lfrac_q <= {lfrac_q[14:0], sqt[32]};
		end
		if (cmd.log_store) begin
			lval_q[cmd.log_idx] <= {ipart_q, lfrac_q};
		end
		if (cmd.lsum) begin
			acc_q <= ((cmd.cnt == '0) ? LOG_BIAS : acc_q) + term;
		end
		if (cmd.exp_load) begin
			mant_q  <= 32'h4000_0000;
			efrac_q <= acc_q[35:20];
			sat_q   <= ip > 6'd61;
			shamt_q <= 6'(6'd62 - ip);
		end
		if (cmd.exp_step) begin
			if (ebit) mant_q <= mprod[61:30];
		end
		if (cmd.mant_div) begin
			mant_q  <= quo[31:0];
			shamt_q <= 6'd32;
			sat_q   <= 1'b0;
		end
		if (cmd.fmul_lo) begin
			plo_q <= dt_q[31:0] * mant_q;
		end
		if (cmd.fmul_hi) begin
			prod72_q <= {phi, 32'b0} + {8'b0, plo_q};
		end
		if (cmd.pid_fin) begin
			pid_q <= pid_d;
		end
		if (cmd.load_out) begin
			new_step <= (pid_q < iter_q) ? pid_q : iter_q;
			pid_case <= pcase_q;
		end
	end

	assign status.pcase = pcase_q;
endmodule

[sv/pid_iteration_step_controller_top.sv]
// Step size controller: each input beat (last step, iteration count,
// relative change) yields one result beat with the smaller of a PID estimate
// and an iteration-count estimate. One item is processed at a time. The
// shared one-bit-per-cycle divider runs a division for the iteration
// estimate and a second one when the error exceeds tolerance, and the
// power formula takes four log2 passes on one squaring multiplier, then
// combines the logs and runs an exp2 pass. A zero in the error history
// gives the shortest path, with no PID division and no log or exp pass.
// A finished result waits in the output register while the next beat is
// accepted. Register writes are taken every cycle; writing the tolerance also
// reloads the error history with it.
module pid_iteration_step_controller_top import pisc_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	pisc_in_if.sink      in_ch,
	pisc_out_if.source   out_ch,
	pisc_cfg_if.sink     cfg_ch
);
	pisc_cmd_t    cmd;
	pisc_status_t status;

	assign cfg_ch.ready = 1'b1;

	pisc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_ch.valid),
		.in_ready  (in_ch.ready),
		.out_valid (out_ch.valid),
		.out_ready (out_ch.ready),
		.status    (status),
		.cmd       (cmd)
	);

	pisc_dp u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.step_size       (in_ch.step_size),
		.iteration_count (in_ch.iteration_count),
		.rel_change      (in_ch.rel_change),
		.cfg_we          (cfg_ch.valid),
		.cfg_index       (cfg_ch.index),
		.cfg_data        (cfg_ch.data),
		.status          (status),
		.new_step        (out_ch.new_step),
		.pid_case        (out_ch.pid_case)
	);
endmodule

[tb/sv/pisc_tb_if.sv]
// Testbench-side note: the channel interfaces come from the RTL files
// (pisc_in_if, pisc_out_if, pisc_cfg_if); this file holds the shared
// stimulus and result record types. Depends on pisc_pkg.
package pisc_tb_pkg;
	import pisc_pkg::*;

	typedef struct {
		logic [STEP_W-1:0] step_size;
		logic [ITER_W-1:0] iteration_count;
		logic [ERR_W-1:0]  rel_change;
	} step_req_t;

	typedef struct {
		logic [STEP_W-1:0] new_step;
		logic [CASE_W-1:0] pid_case;
	} step_res_t;
endpackage

[tb/sv/pid_iteration_step_controller_top_tb.sv]
// Testbench for the PID and iteration step size controller: random and
// directed solver steps are checked against a behavioral predictor.
// Depends on pisc_pkg, pisc_tb_pkg and the channel interfaces.
module pid_iteration_step_controller_top_tb;
	import pisc_pkg::*;
	import pisc_tb_pkg::*;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	always #5 clk = ~clk;

	pisc_in_if  in_ch();
	pisc_out_if out_ch();
	pisc_cfg_if cfg_ch();

	pid_iteration_step_controller_top u_top (
		.clk(clk), .arst_n(arst_n), .in_ch(in_ch), .out_ch(out_ch), .cfg_ch(cfg_ch)
	);

	// Predictor copy of the registers and the error history.
	logic [31:0] tol_q;
	logic [7:0]  target_q;
	logic [15:0] decay_q;
	logic [15:0] growth_q;
	logic [39:0] min_step_q;
	logic [31:0] hist_q [3];

	step_res_t step_expect_q[$];
	int        fail_cnt = 0;
	bit        hold_off = 1'b0;
	bit        free_run = 1'b0;

	initial begin
		in_ch.valid = 1'b0;
		in_ch.step_size = '0;
		in_ch.iteration_count = '0;
		in_ch.rel_change = '0;
		out_ch.ready = 1'b0;
		cfg_ch.valid = 1'b0;
		cfg_ch.index = CFG_TOLERANCE;
		cfg_ch.data = '0;
	end

	function automatic logic [39:0] sat_shift(logic [127:0] p, int s);
		logic [127:0] r;
		if (s <= 0 || s > 63) return STEP_MAX;
		r = p >> s;
		if (r > {88'd0, STEP_MAX}) return STEP_MAX;
		return r[39:0];
	endfunction

	function automatic longint log2_fix(logic [31:0] x);
		int          n;
		logic [63:0] y;
		longint      frac;
		n = 31;
		while (n > 0 && !x[n]) n--;
		y = {32'd0, x} << (31 - n);
		y = y & 64'hFFFF_FFFF;
		frac = 0;
		for (int i = 0; i < 16; i++) begin
			y = (y * y) >> 31;
			frac = frac << 1;
			if (y >= 64'h1_0000_0000) begin
				frac = frac | 1;
				y = y >> 1;
			end
		end
		return (longint'(n) << 16) | frac;
	endfunction

	function automatic longint unsigned int_sqrt(longint unsigned v);
		longint unsigned res, bv;
		res = 0;
		bv = 64'h4000_0000_0000_0000;
		while (bv > v) bv = bv >> 2;
		while (bv != 0) begin
			if (v >= res + bv) begin
				v = v - (res + bv);
				res = (res >> 1) + bv;
			end else begin
				res = res >> 1;
			end
			bv = bv >> 2;
		end
		return res;
	endfunction

	function automatic logic [39:0] power_estimate(logic [39:0] dt);
		longint          l0, l1, l2, lt, l36;
		longint unsigned b16, ip, m, c;
		logic [127:0]    prod;
		l0 = log2_fix(hist_q[0]);
		l1 = log2_fix(hist_q[1]);
		l2 = log2_fix(hist_q[2]);
		lt = log2_fix(tol_q);
		l36 = 78643 * (l1 - l2) + 183501 * (lt - l2) + 10486 * (2 * l1 - l0 - l2);
		b16 = longint'(l36 + (longint'(32) << 36)) >> 20;
		ip = b16 >> 16;
		if (ip > 61) return STEP_MAX;
		m = 64'd1 << 30;
		c = 64'd1 << 31;
		for (int k = 1; k <= 16; k++) begin
			c = int_sqrt(c << 30);
			if ((b16 >> (16 - k)) & 1) m = (m * c) >> 30;
		end
		prod = {88'd0, dt} * {64'd0, m};
		return sat_shift(prod, 62 - int'(ip));
	endfunction

	function automatic step_res_t predict_step(step_req_t rq);
		step_res_t    r;
		logic [39:0]  pid, iter;
		logic [127:0] num, den, prod;
		logic [63:0]  ratio;
		logic [127:0] t;
		hist_q[0] = hist_q[1];
		hist_q[1] = hist_q[2];
		hist_q[2] = rq.rel_change;
		t = (target_q == 0) ? 1 : target_q;
		if (rq.rel_change > tol_q) begin
			ratio = ({32'd0, tol_q} << 32) / rq.rel_change;
			prod = {88'd0, rq.step_size} * {64'd0, ratio};
			pid = sat_shift(prod, 32);
			r.pid_case = PC_OVER_TOL;
		end else if (hist_q[0] == 0 || hist_q[1] == 0 || rq.rel_change == 0) begin
			pid = STEP_MAX;
			r.pid_case = PC_ZERO_HIST;
		end else begin
			pid = power_estimate(rq.step_size);
			r.pid_case = PC_POWER;
		end
		if (rq.iteration_count > t) begin
			num = rq.step_size * t * 4096;
			den = t * 4096 + (rq.iteration_count - t) * decay_q;
			num = num / den;
			iter = num[39:0];
			if (iter < min_step_q) iter = min_step_q;
		end else begin
			num = rq.step_size + (rq.step_size * (t - rq.iteration_count) * growth_q)
				/ (t * 4096);
			iter = (num > {88'd0, STEP_MAX}) ? STEP_MAX : num[39:0];
		end
		r.new_step = (pid < iter) ? pid : iter;
		return r;
	endfunction

	// Valid stays high into the next beat when that beat has no gap.
	task automatic send_step(step_req_t rq);
		int gap;
		gap = free_run ? 0 : $urandom_range(0, 17);
		if (gap != 0) begin
			in_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_ch.step_size <= rq.step_size;
		in_ch.iteration_count <= rq.iteration_count;
		in_ch.rel_change <= rq.rel_change;
		in_ch.valid <= 1'b1;
		@(posedge clk);
		while (!in_ch.ready) @(posedge clk);
		step_expect_q = {step_expect_q, predict_step(rq)};
		@(negedge clk);
	endtask

	task automatic write_reg(logic [2:0] idx, logic [39:0] val);
		@(negedge clk);
		cfg_ch.index <= idx;
		cfg_ch.data <= val;
		cfg_ch.valid <= 1'b1;
		@(posedge clk);
		while (!cfg_ch.ready) @(posedge clk);
		case (idx)
			CFG_TOLERANCE: begin
				tol_q = val[31:0];
				for (int i = 0; i < 3; i++) hist_q[i] = val[31:0];
			end
			CFG_TARGET_ITER: target_q = val[7:0];
			CFG_DECAY:       decay_q = val[15:0];
			CFG_GROWTH:      growth_q = val[15:0];
			CFG_MIN_STEP:    min_step_q = val;
			default: ;
		endcase
		@(negedge clk);
		cfg_ch.valid <= 1'b0;
	endtask

	task automatic drain_results();
		in_ch.valid <= 1'b0;
		while (step_expect_q.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		@(negedge clk);
	endtask

	function automatic step_req_t rand_step();
		step_req_t rq;
		int        pick;
		pick = $urandom_range(0, 9);
		rq.step_size = 40'({$urandom, $urandom});
		if (pick < 4) rq.step_size = rq.step_size >> $urandom_range(0, 39);
		rq.iteration_count = 8'($urandom_range(0, 255));
		if (pick < 6) rq.iteration_count = 8'($urandom_range(0, 2 * target_q + 2));
		rq.rel_change = $urandom;
		case (pick)
			0, 1, 2: rq.rel_change = tol_q >> $urandom_range(0, 8);
			3:       rq.rel_change = '0;
			4:       rq.rel_change = tol_q + 32'($urandom_range(0, 3));
			5:       rq.rel_change = rq.rel_change >> $urandom_range(0, 31);
			default: ;
		endcase
		return rq;
	endfunction

	// Result checker with random receiver stalls.
	initial begin
		int        stall;
		step_res_t exp_r;
		@(posedge arst_n);
		forever begin
			stall = (free_run || hold_off) ? 0 : $urandom_range(0, 17);
			if (stall != 0 || hold_off) begin
				out_ch.ready <= 1'b0;
				repeat (stall) @(negedge clk);
				while (hold_off) @(negedge clk);
			end
			out_ch.ready <= 1'b1;
			@(posedge clk);
			while (!out_ch.valid) @(posedge clk);
			if (step_expect_q.size() == 0) begin
				$display("%0t: unexpected result new_step=%h pid_case=%0d", $time,
					out_ch.new_step, out_ch.pid_case);
				fail_cnt++;
			end else begin
				exp_r = step_expect_q.pop_front();
				if (out_ch.new_step !== exp_r.new_step) begin
					$display("%0t: new_step expected %h actual %h", $time,
						exp_r.new_step, out_ch.new_step);
					fail_cnt++;
				end
				if (out_ch.pid_case !== exp_r.pid_case) begin
					$display("%0t: pid_case expected %0d actual %0d", $time,
						exp_r.pid_case, out_ch.pid_case);
					fail_cnt++;
				end
			end
			@(negedge clk);
		end
	end

	task automatic test_directed();
		step_req_t rq;
		logic [39:0] sizes [4] = '{40'd0, 40'd1, 40'h00_0001_0000, STEP_MAX};
		logic [31:0] errs [6];
		errs = '{32'd0, 32'd1, tol_q, tol_q + 32'd1, 32'hFFFF_FFFF, tol_q >> 1};
		for (int i = 0; i < 24; i++) begin
			rq.step_size = sizes[i % 4];
			rq.iteration_count = (i % 3 == 0) ? 8'd0 : (i % 3 == 1) ? 8'd255 : 8'd8;
			rq.rel_change = errs[i % 6];
			send_step(rq);
		end
		drain_results();
	endtask

	task automatic test_config_extremes();
		write_reg(CFG_TOLERANCE, 40'hFF_FFFF_FFFF);
		write_reg(CFG_TARGET_ITER, 40'd255);
		write_reg(CFG_DECAY, 40'd0);
		write_reg(CFG_GROWTH, 40'd65535);
		write_reg(CFG_MIN_STEP, STEP_MAX);
		for (int i = 0; i < 60; i++) send_step(rand_step());
		drain_results();
		write_reg(CFG_TOLERANCE, 40'd1);
		write_reg(CFG_TARGET_ITER, 40'd0);
		write_reg(CFG_DECAY, 40'd65535);
		write_reg(CFG_GROWTH, 40'd0);
		write_reg(CFG_MIN_STEP, 40'd0);
		for (int i = 0; i < 60; i++) send_step(rand_step());
		drain_results();
	endtask

	task automatic test_random_settings();
		for (int ph = 0; ph < 10; ph++) begin
			write_reg(CFG_TOLERANCE, 40'($urandom_range(1, 32'hFFFF_FFFF)));
			write_reg(CFG_TARGET_ITER, 40'($urandom_range(1, 40)));
			write_reg(CFG_DECAY, 40'($urandom_range(0, 65535)));
			write_reg(CFG_GROWTH, 40'($urandom_range(0, 65535)));
			write_reg(CFG_MIN_STEP, 40'({$urandom, $urandom} >> $urandom_range(24, 63)));
			for (int i = 0; i < 85; i++) send_step(rand_step());
			drain_results();
		end
	endtask

	// The receiver stops for a long stretch while the sender keeps offering.
	task automatic test_backpressure();
		fork
			begin
				hold_off = 1'b1;
				repeat (600) @(posedge clk);
				hold_off = 1'b0;
			end
			begin
				free_run = 1'b1;
				for (int i = 0; i < 8; i++) send_step(rand_step());
				in_ch.valid <= 1'b0;
				free_run = 1'b0;
			end
		join
		drain_results();
		for (int i = 0; i < 60; i++) send_step(rand_step());
		drain_results();
	endtask

	initial begin
		tol_q = TOL_RESET;
		target_q = TARGET_RESET;
		decay_q = DAMP_RESET;
		growth_q = DAMP_RESET;
		min_step_q = '0;
		for (int i = 0; i < 3; i++) hist_q[i] = TOL_RESET;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		test_directed();
		test_config_extremes();
		test_random_settings();
		test_backpressure();
		if (fail_cnt == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

	initial begin
		#20000000;
		$display("simulation failed");
		$finish;
	end
endmodule
